### rtl/fmc_pkg.sv
// ----------------------------------------------------------------------------
// fmc_pkg
// Shared types and constants for the float/minifloat converter.
// ----------------------------------------------------------------------------
package fmc_pkg;

  localparam int unsigned IEEE_MANT_W = 23;
  localparam logic [7:0]  IEEE_BIAS   = 8'd127;

  // Configuration register indexes
  localparam logic [7:0] CFG_EXP_BITS  = 8'd0;
  localparam logic [7:0] CFG_MANT_BITS = 8'd1;

  // Legal ranges and reset values of the format widths
  localparam logic [3:0] EXP_BITS_MIN   = 4'd2;
  localparam logic [3:0] EXP_BITS_MAX   = 4'd8;
  localparam logic [3:0] EXP_BITS_RST   = 4'd5;
  localparam logic [4:0] MANT_BITS_MIN  = 5'd2;
  localparam logic [4:0] MANT_BITS_MAX  = 5'd23;
  localparam logic [4:0] MANT_BITS_RST  = 5'd10;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic {
    ACT_PACK   = 1'b0,
    ACT_UNPACK = 1'b1
  } action_e;

  typedef struct packed {
    logic        action;
    logic [31:0] operand_bits;
  } in_t;

  typedef struct packed {
    logic [31:0] converted_bits;
    logic        clamped;
  } out_t;

  typedef struct packed {
    logic [3:0] exp_bits;
    logic [4:0] mant_bits;
  } fmt_cfg_t;

endpackage

### rtl/fmc_cfg.sv
// ----------------------------------------------------------------------------
// fmc_cfg
// Format width registers; written values are saturated into their legal range.
// ----------------------------------------------------------------------------
module fmc_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [fmc_pkg::CFG_IDX_W-1:0]       wr_index_i,
  input  logic [fmc_pkg::CFG_DATA_W-1:0]      wr_data_i,
  output fmc_pkg::fmt_cfg_t                   cfg_o
);

  logic [3:0] exp_bits_q, exp_bits_d, exp_raw;
  logic [4:0] mant_bits_q, mant_bits_d, mant_raw;

  assign exp_raw  = wr_data_i[3:0];
  assign mant_raw = wr_data_i[4:0];

  always_comb begin
    exp_bits_d  = exp_bits_q;
    mant_bits_d = mant_bits_q;
    if (wr_en_i && (wr_index_i == fmc_pkg::CFG_EXP_BITS)) begin
      if (exp_raw < fmc_pkg::EXP_BITS_MIN) begin
        exp_bits_d = fmc_pkg::EXP_BITS_MIN;
      end else if (exp_raw > fmc_pkg::EXP_BITS_MAX) begin
        exp_bits_d = fmc_pkg::EXP_BITS_MAX;
      end else begin
        exp_bits_d = exp_raw;
      end
    end
    if (wr_en_i && (wr_index_i == fmc_pkg::CFG_MANT_BITS)) begin
      if (mant_raw < fmc_pkg::MANT_BITS_MIN) begin
        mant_bits_d = fmc_pkg::MANT_BITS_MIN;
      end else if (mant_raw > fmc_pkg::MANT_BITS_MAX) begin
        mant_bits_d = fmc_pkg::MANT_BITS_MAX;
      end else begin
        mant_bits_d = mant_raw;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_bits_q  <= fmc_pkg::EXP_BITS_RST;
      mant_bits_q <= fmc_pkg::MANT_BITS_RST;
    end else begin
      exp_bits_q  <= exp_bits_d;
      mant_bits_q <= mant_bits_d;
    end
  end

  assign cfg_o.exp_bits  = exp_bits_q;
  assign cfg_o.mant_bits = mant_bits_q;

endmodule

### rtl/fmc_core.sv
// ----------------------------------------------------------------------------
// fmc_core
// Combinational pack/unpack datapath for one operand.
// ----------------------------------------------------------------------------
module fmc_core (
  input  fmc_pkg::fmt_cfg_t cfg_i,
  input  fmc_pkg::in_t      in_i,
  output fmc_pkg::out_t     out_o
);

  logic [3:0]  ew;        // E
  logic [4:0]  mw;        // M
  logic [2:0]  ee;        // E-1, exponent magnitude width
  logic [5:0]  em_sum;    // E+M, position of the sign bit
  logic [4:0]  esign_pos; // E-1+M
  logic [4:0]  msh;       // 23-M
  logic [6:0]  emask;
  logic [22:0] mmask;
  logic [31:0] width_mask;
  logic [31:0] max_code, min_code;
  logic [7:0]  min_ef;
  logic [7:0]  vmax_exp, vmin_exp;
  logic [30:0] vmax, vmin;

  // Pack side
  logic        neg, is_nan, mag_zero, pk_esign;
  logic [30:0] mag;
  logic [7:0]  bexp, absu, ef;
  logic [22:0] mant;
  logic [31:0] repack;

  // Unpack side
  logic [31:0] code;
  logic        u_sign, u_esign;
  logic [6:0]  u_emag;
  logic [22:0] u_mant;
  logic [7:0]  u_biased;

  assign ew        = cfg_i.exp_bits;
  assign mw        = cfg_i.mant_bits;
  assign ee        = 3'(ew - 4'd1);
  assign em_sum    = 6'(ew) + 6'(mw);
  assign esign_pos = 5'(em_sum - 6'd1);
  assign msh       = 5'(fmc_pkg::IEEE_MANT_W) - mw;
  assign emask     = 7'((8'd1 << ee) - 8'd1);
  assign mmask     = 23'((24'd1 << mw) - 24'd1);
  assign width_mask = 32'((33'd1 << (em_sum + 6'd1)) - 33'd1);

  // Extreme codes and their IEEE magnitudes
  assign max_code = (32'(emask) << mw) | 32'(mmask);
  assign min_ef   = 8'((9'd1 << ew) - 9'd2);
  assign min_code = (32'(min_ef) << mw) | 32'd1;
  assign vmax_exp = fmc_pkg::IEEE_BIAS + 8'(emask);
  assign vmin_exp = fmc_pkg::IEEE_BIAS - 8'(emask - 7'd1);
  assign vmax     = {vmax_exp, 23'(mmask << msh)};
  assign vmin     = {vmin_exp, 23'(23'd1 << msh)};

  // Pack
  assign neg      = in_i.operand_bits[31];
  assign mag      = in_i.operand_bits[30:0];
  assign bexp     = in_i.operand_bits[30:23];
  assign mant     = in_i.operand_bits[22:0];
  assign is_nan   = (bexp == 8'hFF) && (mant != 23'd0);
  assign mag_zero = (mag == 31'd0);
  assign pk_esign = (bexp < fmc_pkg::IEEE_BIAS);
  assign absu     = pk_esign ? (fmc_pkg::IEEE_BIAS - bexp) : (bexp - fmc_pkg::IEEE_BIAS);
  assign ef       = (8'(pk_esign) << ee) | 8'(absu[6:0] & emask);
  assign repack   = (32'(neg) << em_sum) | (32'(ef) << mw) | 32'(mant >> msh);

  // Unpack; bits above the small format are dropped
  assign code     = in_i.operand_bits & width_mask;
  assign u_sign   = code[em_sum[4:0]];
  assign u_esign  = code[esign_pos];
  assign u_emag   = 7'(code >> mw) & emask;
  assign u_mant   = (23'(code) & mmask) << msh;
  assign u_biased = u_esign ? (fmc_pkg::IEEE_BIAS - 8'(u_emag))
                            : (fmc_pkg::IEEE_BIAS + 8'(u_emag));

  always_comb begin
    out_o.clamped        = 1'b0;
    out_o.converted_bits = repack;
    if (in_i.action == fmc_pkg::ACT_UNPACK) begin
      out_o.converted_bits = {u_sign, u_biased, u_mant};
    end else if (!is_nan && (mag >= vmax)) begin
      out_o.converted_bits = max_code | (32'(neg) << em_sum);
      out_o.clamped        = 1'b1;
    end else if (!is_nan && (mag <= vmin)) begin
      out_o.converted_bits = min_code | (32'(neg && !mag_zero) << em_sum);
      out_o.clamped        = 1'b1;
    end
  end

endmodule

### rtl/float_minifloat_converter.sv
// ----------------------------------------------------------------------------
// float_minifloat_converter
// Converts IEEE single patterns to a configurable minifloat and back.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one beat per
//   operand: an action (pack or unpack) and a 32-bit operand. Output channel
//   (out_valid_o / out_stall_i / out_data_o) returns one beat per operand with
//   the converted pattern and a clamp flag, in order.
//   An input beat passes one input register, the single-pass conversion
//   logic and one result register on its way to the output. Throughput is
//   one beat per cycle while the output is not stalled; each pipeline stage
//   advances whenever the stage ahead of it is empty or moving, so a new
//   operand is taken while an earlier result waits at the output.
//   When the receiver stalls, the result register holds its beat, the input
//   register fills, and then in_stall_o rises until the output moves again.
//   The config channel (cfg_valid_i / cfg_ready_o) is always ready; index 0
//   sets the exponent width, index 1 the mantissa width, other indexes are
//   dropped. Write only while the pipeline is empty.
//   Reset empties both stages and restores the widths to 5 and 10 bits.
// ----------------------------------------------------------------------------
module float_minifloat_converter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  fmc_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output fmc_pkg::out_t                    out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fmc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fmc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  fmc_pkg::fmt_cfg_t fmt_cfg;
  fmc_pkg::in_t      in_q;
  fmc_pkg::out_t     res_d, res_q;
  logic              in_vld_q, res_vld_q;
  logic              adv_res, adv_in;

  // Config writes are taken every cycle
  assign cfg_ready_o = 1'b1;

  fmc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (fmt_cfg)
  );

  // Advance the result stage when it is empty or its beat is being taken;
  // advance the input stage when it is empty or drains into the result stage.
  assign adv_res    = !res_vld_q || !out_stall_i;
  assign adv_in     = !in_vld_q || adv_res;
  assign in_stall_o = !adv_in;

  // Control valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (adv_in) begin
        in_vld_q <= in_valid_i;
      end
      if (adv_res) begin
        res_vld_q <= in_vld_q;
      end
    end
  end

  // Payload registers; hold while stalled
  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (adv_res && in_vld_q) begin
      res_q <= res_d;
    end
  end

  fmc_core u_core (
    .cfg_i (fmt_cfg),
    .in_i  (in_q),
    .out_o (res_d)
  );

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the float/minifloat converter.
// Feeds pack and unpack beats through the stall handshake under bursty traffic
// and receiver back-pressure, predicts every result in the bench, and compares
// each output beat field by field in order. Sweeps several format widths,
// including the narrowest and widest, between drained phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned PHASE_OPS     = 205;
  localparam int unsigned HOLDOFF_LEN   = 40;
  localparam int unsigned HOLDOFF_STEP  = 450;

  // Receiver stall patterns
  localparam int unsigned STALL_NONE  = 0;
  localparam int unsigned STALL_LIGHT = 1;
  localparam int unsigned STALL_HEAVY = 2;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  fmc_pkg::in_t                   in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  fmc_pkg::out_t                  out_data_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [fmc_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [fmc_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Format widths as the block holds them after saturation
  int unsigned exp_w  = fmc_pkg::EXP_BITS_RST;
  int unsigned mant_w = fmc_pkg::MANT_BITS_RST;

  // Raw register values per phase; some lie outside the legal range on purpose
  int unsigned exp_setting  [9] = '{2, 8, 2, 8, 0, 15, 4, 3, 32'hFFFF_FFF6};
  int unsigned mant_setting [9] = '{2, 23, 23, 2, 32'h3F, 1, 7, 16, 32'hFFFF_FFEC};

  fmc_pkg::in_t  operand_q[$];      // beats waiting to be offered
  fmc_pkg::out_t conv_expect_q[$];  // predicted results, oldest first
  fmc_pkg::out_t want_res;

  int unsigned cycle_cnt    = 0;
  int unsigned accepted_cnt = 0;
  int unsigned mismatch_cnt = 0;
  logic        in_taken     = 1'b0;

  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  int unsigned holdoff_left    = 0;
  int unsigned next_holdoff_at = 300;
  int unsigned stall_mode      = STALL_NONE;
  int unsigned mode_left       = 0;

  float_minifloat_converter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Format arithmetic
  // --------------------------------------------------------------------------
  function automatic int unsigned clip_width(int unsigned v, int unsigned lo,
                                             int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Largest code: positive exponent at full magnitude, all-ones mantissa.
  // Smallest code: negative exponent one below full magnitude, mantissa of one.
  function automatic logic [31:0] limit_code(bit want_max);
    logic [31:0] emask;
    logic [31:0] mmask;
    emask = (32'd1 << (exp_w - 1)) - 32'd1;
    mmask = (32'd1 << mant_w) - 32'd1;
    if (want_max) return (emask << mant_w) | mmask;
    return (((32'd1 << exp_w) - 32'd2) << mant_w) | 32'd1;
  endfunction

  // Rebuild the IEEE pattern of a small code already cut to the format width
  function automatic logic [31:0] unpack_code(logic [31:0] code);
    logic [31:0] sgn;
    logic [31:0] esg;
    logic [31:0] emag;
    logic [31:0] mant;
    logic [31:0] biased;
    sgn    = (code >> (exp_w + mant_w)) & 32'd1;
    esg    = (code >> (exp_w - 1 + mant_w)) & 32'd1;
    emag   = (code >> mant_w) & ((32'd1 << (exp_w - 1)) - 32'd1);
    mant   = (code & ((32'd1 << mant_w) - 32'd1)) << (fmc_pkg::IEEE_MANT_W - mant_w);
    // a zero magnitude with the sign set still lands on the bias
    biased = (esg != 0) ? (32'(fmc_pkg::IEEE_BIAS) - emag)
                        : (32'(fmc_pkg::IEEE_BIAS) + emag);
    return (sgn << 31) | ((biased & 32'hFF) << fmc_pkg::IEEE_MANT_W) | mant;
  endfunction

  // Expected result of one input beat under the current widths
  function automatic fmc_pkg::out_t minifloat_convert(fmc_pkg::in_t item);
    logic [31:0]   x;
    logic [31:0]   wmask;
    logic [31:0]   emask;
    logic [31:0]   sign_code;
    logic [31:0]   max_c;
    logic [31:0]   min_c;
    logic [31:0]   vmax;
    logic [31:0]   vmin;
    logic [31:0]   mag;
    logic [31:0]   neg;
    logic [31:0]   bexp;
    logic [31:0]   mant;
    logic [31:0]   esg;
    logic [31:0]   absu;
    logic          is_nan;
    fmc_pkg::out_t res;
    x           = item.operand_bits;
    wmask       = 32'((64'd1 << (exp_w + mant_w + 1)) - 64'd1);
    emask       = (32'd1 << (exp_w - 1)) - 32'd1;
    sign_code   = 32'd1 << (exp_w + mant_w);
    res.clamped = 1'b0;
    if (item.action == fmc_pkg::ACT_UNPACK) begin
      // bits above the sign of the small format are dropped
      res.converted_bits = unpack_code(x & wmask);
    end else begin
      max_c  = limit_code(1'b1);
      min_c  = limit_code(1'b0);
      vmax   = unpack_code(max_c);
      vmin   = unpack_code(min_c);
      mag    = x & 32'h7FFF_FFFF;
      neg    = x >> 31;
      bexp   = (x >> fmc_pkg::IEEE_MANT_W) & 32'hFF;
      mant   = x & 32'h007F_FFFF;
      is_nan = (bexp == 32'hFF) && (mant != 0);
      if (!is_nan && mag >= vmax) begin
        // saturate high, infinities included
        res.converted_bits = max_c | ((neg != 0) ? sign_code : 32'd0);
        res.clamped        = 1'b1;
      end else if (!is_nan && mag <= vmin) begin
        // saturate low; minus zero keeps a clear sign
        res.converted_bits = min_c | ((neg != 0 && mag != 0) ? sign_code : 32'd0);
        res.clamped        = 1'b1;
      end else begin
        // repack by truncation, NaN included
        esg  = (bexp < 32'(fmc_pkg::IEEE_BIAS)) ? 32'd1 : 32'd0;
        absu = (esg != 0) ? (32'(fmc_pkg::IEEE_BIAS) - bexp)
                          : (bexp - 32'(fmc_pkg::IEEE_BIAS));
        res.converted_bits = (neg << (exp_w + mant_w))
                           | (((esg << (exp_w - 1)) | (absu & emask)) << mant_w)
                           | (mant >> (fmc_pkg::IEEE_MANT_W - mant_w));
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Random beats, weighted toward the interesting regions of the format
  // --------------------------------------------------------------------------
  function automatic fmc_pkg::in_t random_operand();
    fmc_pkg::in_t item;
    int unsigned  pick;
    int unsigned  span;
    logic [31:0]  bexp;
    logic [31:0]  v;
    pick        = $urandom_range(0, 99);
    item.action = fmc_pkg::ACT_PACK;
    if (pick < 12) begin
      // unpack with junk above the format
      item.action       = fmc_pkg::ACT_UNPACK;
      item.operand_bits = $urandom();
    end else if (pick < 32) begin
      item.action       = fmc_pkg::ACT_UNPACK;
      item.operand_bits = $urandom() & 32'((64'd1 << (exp_w + mant_w + 1)) - 64'd1);
    end else if (pick < 42) begin
      item.operand_bits = $urandom();
    end else if (pick < 78) begin
      // exponent within the representable range, random mantissa
      span = (32'd1 << (exp_w - 1)) - 1;
      bexp = 32'(fmc_pkg::IEEE_BIAS) + $urandom_range(0, 2 * span) - span;
      v    = $urandom();
      item.operand_bits = {v[31], bexp[7:0], v[22:0]};
    end else if (pick < 92) begin
      // one step around either saturation threshold
      v = unpack_code(limit_code(pick < 85)) + $urandom_range(0, 2) - 1;
      v[31] = $urandom_range(0, 1);
      item.operand_bits = v;
    end else begin
      v = $urandom();
      case ($urandom_range(0, 3))
        0:       item.operand_bits = {v[31], 31'd0};
        1:       item.operand_bits = {v[31], 8'hFF, 23'd0};
        2:       item.operand_bits = {v[31], 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
        default: item.operand_bits = {v[31], 8'h00, v[22:0]};
      endcase
    end
    return item;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration and drain helpers
  // --------------------------------------------------------------------------
  // Leave cfg_valid_i high on return; the caller drops it after its last write
  task automatic cfg_write(logic [fmc_pkg::CFG_IDX_W-1:0] idx,
                           logic [fmc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == fmc_pkg::CFG_EXP_BITS)
      exp_w = clip_width(data & 32'hF, fmc_pkg::EXP_BITS_MIN, fmc_pkg::EXP_BITS_MAX);
    else if (idx == fmc_pkg::CFG_MANT_BITS)
      mant_w = clip_width(data & 32'h1F, fmc_pkg::MANT_BITS_MIN, fmc_pkg::MANT_BITS_MAX);
  endtask

  // Wait until every beat is offered, taken and answered, then let the
  // two-stage pipeline settle
  task automatic wait_drained(int unsigned settle);
    while (operand_q.size() != 0 || in_valid_i || conv_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer beats in bursts with random gaps; hold a beat while stalled
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (operand_q.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= operand_q.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // new burst; a third of them follow without any gap
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall: random patterns, plus a long hold-off every few hundred
  // accepted beats so the pipeline fills and pushes back on the sender
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else if (accepted_cnt >= next_holdoff_at) begin
      holdoff_left    = HOLDOFF_LEN - 1;
      next_holdoff_at = next_holdoff_at + HOLDOFF_STEP;
      out_stall_i    <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
        mode_left  = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        default:     out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check output beats first, then record the input beat taken at
  // this edge so a same-edge push can never mask an unexpected result
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (conv_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h clamp %0b",
                   $time, out_data_o.converted_bits, out_data_o.clamped);
          mismatch_cnt++;
        end else begin
          want_res = conv_expect_q.pop_front();
          if (out_data_o.converted_bits !== want_res.converted_bits) begin
            $display("%0t: converted_bits mismatch, expected %h actual %h",
                     $time, want_res.converted_bits, out_data_o.converted_bits);
            mismatch_cnt++;
          end
          if (out_data_o.clamped !== want_res.clamped) begin
            $display("%0t: clamped mismatch, expected %0b actual %0b",
                     $time, want_res.clamped, out_data_o.clamped);
            mismatch_cnt++;
          end
        end
      end
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        conv_expect_q.push_back(minifloat_convert(in_data_i));
        accepted_cnt++;
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed beats at reset widths, then one random phase per
  // width setting with the pipeline drained before each register write
  // --------------------------------------------------------------------------
  initial begin
    int unsigned ph;
    int unsigned n;
    logic [31:0] vmax;
    logic [31:0] vmin;
    logic [31:0] sign_code;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    vmax      = unpack_code(limit_code(1'b1));
    vmin      = unpack_code(limit_code(1'b0));
    sign_code = 32'd1 << (exp_w + mant_w);

    // zeros, infinities, NaNs and denormals
    operand_q.push_back('{fmc_pkg::ACT_PACK, 32'h0000_0000});
    operand_q.push_back('{fmc_pkg::ACT_PACK, 32'h8000_0000});
    operand_q.push_back('{fmc_pkg::ACT_PACK, 32'h7F80_0000});
    operand_q.push_back('{fmc_pkg::ACT_PACK, 32'hFF80_0000});
    operand_q.push_back('{fmc_pkg::ACT_PACK, 32'h7FC0_0000});
    operand_q.push_back('{fmc_pkg::ACT_PACK, 32'hFF80_0001});
    operand_q.push_back('{fmc_pkg::ACT_PACK, 32'h0000_0001});
    operand_q.push_back('{fmc_pkg::ACT_PACK, 32'h807F_FFFF});
    // ordinary values and the largest finite single
    operand_q.push_back('{fmc_pkg::ACT_PACK, 32'h3F80_0000});
    operand_q.push_back('{fmc_pkg::ACT_PACK, 32'hBF00_0000});
    operand_q.push_back('{fmc_pkg::ACT_PACK, 32'h4000_0000});
    operand_q.push_back('{fmc_pkg::ACT_PACK, 32'h7F7F_FFFF});
    // either side of both saturation thresholds
    operand_q.push_back('{fmc_pkg::ACT_PACK, vmax});
    operand_q.push_back('{fmc_pkg::ACT_PACK, vmax - 32'd1});
    operand_q.push_back('{fmc_pkg::ACT_PACK, (vmax + 32'd1) | 32'h8000_0000});
    operand_q.push_back('{fmc_pkg::ACT_PACK, vmin});
    operand_q.push_back('{fmc_pkg::ACT_PACK, vmin + 32'd1});
    operand_q.push_back('{fmc_pkg::ACT_PACK, vmin | 32'h8000_0000});
    operand_q.push_back('{fmc_pkg::ACT_PACK, vmin - 32'd1});
    // unpack: zero, all ones with junk above the format, negative zero
    // exponent, both limit codes
    operand_q.push_back('{fmc_pkg::ACT_UNPACK, 32'h0000_0000});
    operand_q.push_back('{fmc_pkg::ACT_UNPACK, 32'hFFFF_FFFF});
    operand_q.push_back('{fmc_pkg::ACT_UNPACK, (32'd1 << (exp_w - 1 + mant_w)) | 32'h15});
    operand_q.push_back('{fmc_pkg::ACT_UNPACK, limit_code(1'b1) | sign_code});
    operand_q.push_back('{fmc_pkg::ACT_UNPACK, limit_code(1'b0)});
    operand_q.push_back('{fmc_pkg::ACT_UNPACK, 32'hA5A5_0000 | limit_code(1'b0)});

    for (ph = 0; ph < 9; ph++) begin
      wait_drained(4);
      cfg_write(fmc_pkg::CFG_EXP_BITS, exp_setting[ph]);
      cfg_write(fmc_pkg::CFG_MANT_BITS, mant_setting[ph]);
      // an index past the register list must change nothing
      cfg_write(8'(fmc_pkg::CFG_MANT_BITS + 1 + $urandom_range(0, 253)), $urandom());
      @(negedge clk_i);
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
      for (n = 0; n < PHASE_OPS; n++)
        operand_q.push_back(random_operand());
    end

    wait_drained(10);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
